[design/thf_pkg.sv]
// ----------------------------------------------------------------------------
// thf_pkg
// Shared types, constants and the row table of the telemetry header filter.
// ----------------------------------------------------------------------------
`default_nettype none

package thf_pkg;

   // Header length limits in bytes
   localparam int unsigned MIN_HEADER_BYTES    = 29;
   localparam int unsigned FLASHBACK_MIN_BYTES = MIN_HEADER_BYTES + 12;
   localparam int unsigned FORMULA_LEN_LIMIT   = 37;

   // Debounce run length and queue depth defaults
   localparam int unsigned DEFAULT_DETECT_RUN  = 3;
   localparam int unsigned DEFAULT_QUEUE_DEPTH = 2;

   // Format words and the offset that maps them onto codes 1..3
   localparam logic [15:0] FORMAT_WORD_FIRST = 16'd2024;
   localparam logic [15:0] FORMAT_WORD_LAST  = 16'd2026;
   localparam logic [15:0] FORMAT_BASE       = 16'd2023;

   // Event tag 'F','L','B','K'
   localparam logic [31:0] FLASHBACK_TAG = 32'h464C_424B;

   // Packet kinds with special handling
   localparam logic [7:0] KIND_MOTION    = 8'd0;
   localparam logic [7:0] KIND_SESSION   = 8'd1;
   localparam logic [7:0] KIND_EVENT     = 8'd3;
   localparam logic [7:0] KIND_TELEMETRY = 8'd6;
   localparam logic [7:0] KIND_MOTION_EX = 8'd13;

   // Format codes: 0 none, 1..3 for 2024..2026
   typedef logic [1:0] fmt_type;
   localparam fmt_type FMT_NONE = 2'd0;
   localparam fmt_type FMT_2026 = 2'd3;

   // Drop causes
   typedef logic [1:0] drop_type;
   localparam drop_type DROP_NONE   = 2'd0;
   localparam drop_type DROP_SHORT  = 2'd1;
   localparam drop_type DROP_FORMAT = 2'd2;
   localparam drop_type DROP_DUP    = 2'd3;

   // Warning events
   typedef logic [1:0] warn_type;
   localparam warn_type WARN_NONE    = 2'd0;
   localparam warn_type WARN_RAISED  = 2'd1;
   localparam warn_type WARN_CLEARED = 2'd2;

   // Classified item handed from front to back
   typedef struct packed {
      drop_type    early_drop;   // short or unknown format, else DROP_NONE
      fmt_type     code;
      logic        formula_pkt;  // session kind, long enough for the formula
      logic        slot_valid;
      logic [1:0]  slot;
      logic [31:0] frame_number;
      logic [7:0]  formula_byte;
      logic        flashback;
      logic [31:0] rewind_frame;
      logic [31:0] rewind_time_bits;
      logic        body_hit;     // full output requested or a row subscribed
   } thf_item_type;

   // Row families selected by each packet kind
   function automatic logic [31:0] kind_rows(input logic [7:0] kind);
      logic [31:0] rows;
      unique case (kind)
         8'd0:    rows = (32'd1 << 11) | (32'd1 << 13);
         8'd1:    rows = 32'd1 << 5;
         8'd2:    rows = (32'd1 << 4) | (32'd1 << 7);
         8'd3:    rows = 32'd1 << 6;
         8'd4:    rows = 32'd1 << 8;
         8'd6:    rows = 32'd1 << 1;
         8'd7:    rows = (32'd1 << 2) | (32'd1 << 9);
         8'd10:   rows = 32'd1 << 3;
         8'd11:   rows = 32'd1 << 14;
         8'd12:   rows = 32'd1 << 10;
         8'd13:   rows = 32'd1 << 12;
         8'd16:   rows = 32'd1 << 1;
         default: rows = 32'd0;
      endcase
      return rows;
   endfunction

endpackage

`default_nettype wire

[design/thf_front.sv]
// ----------------------------------------------------------------------------
// thf_front
// Accepts header items, classifies them and holds them in one pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module thf_front
   import thf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   // Incoming header item
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire logic [10:0]   datagram_length,
   input  wire logic [15:0]   format_word,
   input  wire logic [7:0]    packet_kind,
   input  wire logic [31:0]   frame_number,
   input  wire logic [7:0]    formula_byte,
   input  wire logic [31:0]   event_tag,
   input  wire logic [31:0]   rewind_frame_in,
   input  wire logic [31:0]   rewind_time_bits_in,
   input  wire logic          want_full_output,
   input  wire logic [31:0]   row_subscription,
   // Classified item towards the queue
   output logic               out_valid,
   input  wire logic          out_ready,
   output thf_item_type       out_item
);

   logic         stage_valid_ff, stage_valid_in;
   thf_item_type stage_item_ff, stage_item_in;
   logic [15:0]  code_full;
   logic         short_pkt, bad_format, time_finite, time_nonneg, flashback;

   // Stage takes an item when empty or when the queue takes the held one
   assign in_ready = !stage_valid_ff || out_ready;

   // Classification
   assign code_full   = format_word - FORMAT_BASE;
   assign short_pkt   = {21'd0, datagram_length} < MIN_HEADER_BYTES;
   assign bad_format  = (format_word < FORMAT_WORD_FIRST) || (format_word > FORMAT_WORD_LAST);
   assign time_finite = rewind_time_bits_in[30:23] != 8'hFF;
   assign time_nonneg = !rewind_time_bits_in[31] || (rewind_time_bits_in[30:0] == 31'd0);
   assign flashback   = (packet_kind == KIND_EVENT) &&
                        ({21'd0, datagram_length} >= FLASHBACK_MIN_BYTES) &&
                        (event_tag == FLASHBACK_TAG) && time_finite && time_nonneg;

   always_comb begin
      stage_item_in.early_drop  = short_pkt  ? DROP_SHORT :
                                  bad_format ? DROP_FORMAT : DROP_NONE;
      stage_item_in.code        = code_full[1:0];
      stage_item_in.formula_pkt = (packet_kind == KIND_SESSION) &&
                                  ({21'd0, datagram_length} > FORMULA_LEN_LIMIT);
      stage_item_in.slot_valid  = (packet_kind == KIND_MOTION) ||
                                  (packet_kind == KIND_TELEMETRY) ||
                                  (packet_kind == KIND_MOTION_EX);
      stage_item_in.slot        = (packet_kind == KIND_MOTION)    ? 2'd0 :
                                  (packet_kind == KIND_TELEMETRY) ? 2'd1 : 2'd2;
      stage_item_in.frame_number     = frame_number;
      stage_item_in.formula_byte     = formula_byte;
      stage_item_in.flashback        = flashback;
      stage_item_in.rewind_frame     = flashback ? rewind_frame_in : 32'd0;
      stage_item_in.rewind_time_bits = flashback ? rewind_time_bits_in : 32'd0;
      stage_item_in.body_hit         = want_full_output ||
                                       ((kind_rows(packet_kind) & row_subscription) != 32'd0);
   end

   // Stage valid
   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (in_ready) begin
         stage_valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         stage_item_ff <= stage_item_in;
      end
   end

   assign out_valid = stage_valid_ff;
   assign out_item  = stage_item_ff;

endmodule

`default_nettype wire

[design/thf_queue.sv]
// ----------------------------------------------------------------------------
// thf_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module thf_queue
   import thf_pkg::*;
#(
   parameter int unsigned DEPTH = DEFAULT_QUEUE_DEPTH   // 2 .. 16
)(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   output logic               push_ready,
   input  wire thf_item_type  push_item,
   output logic               pop_valid,
   input  wire logic          pop_ready,
   output thf_item_type       pop_item
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   thf_item_type entry_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef NO_ASSERTIONS
   // Fill count never passes the depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue fill count beyond depth");

   // Pointers agree with the fill count when empty
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers differ while empty");
`endif

endmodule

`default_nettype wire

[design/thf_back.sv]
// ----------------------------------------------------------------------------
// thf_back
// Format tracking, warning, formula and duplicate state; result register.
// ----------------------------------------------------------------------------
`default_nettype none

module thf_back
   import thf_pkg::*;
#(
   parameter int unsigned DETECT_RUN = DEFAULT_DETECT_RUN   // 1 .. 3
)(
   input  wire logic          clock,
   input  wire logic          reset,
   // Override register write
   input  wire logic          cfg_write,
   input  wire logic [1:0]    cfg_data,
   // Classified item from the queue
   input  wire logic          item_valid,
   output logic               item_ready,
   input  wire thf_item_type  item,
   // Result
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output drop_type           drop_cause,
   output logic [10:0]        effective_format,
   output logic [1:0]         status_events,
   output warn_type           warning_event,
   output logic               flashback_seen,
   output logic [31:0]        rewind_frame_out,
   output logic [31:0]        rewind_time_bits_out,
   output logic               parse_body
);

   // Tracking state
   logic [1:0]  override_ff, override_in;
   fmt_type     cand_fmt_ff, cand_fmt_in;
   logic [1:0]  cand_run_ff, cand_run_in;
   fmt_type     detected_ff, detected_in;
   fmt_type     active_ff, active_in;
   logic        warn_raised_ff, warn_raised_in;
   fmt_type     warn_fmt_ff, warn_fmt_in;
   logic        formula_known_ff, formula_known_in;
   logic [7:0]  formula_value_ff, formula_value_in;
   logic        seen_valid_ff [3];
   logic        seen_valid_in [3];
   logic [31:0] seen_num_ff [3];
   logic [31:0] seen_num_in [3];

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   drop_type    drop_ff, drop_in;
   logic [10:0] eff_word_ff, eff_word_in;
   logic [1:0]  status_ff, status_in;
   warn_type    warn_ff, warn_in;
   logic        flash_ff, flash_in;
   logic [31:0] rframe_ff, rframe_in;
   logic [31:0] rtime_ff, rtime_in;
   logic        parse_ff, parse_in;

   logic        take;
   logic        detect_hit, clear_sess, dup;
   fmt_type     active_mid, eff;
   logic [15:0] eff_word_full;

   // Result register frees up when empty or being taken
   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign take       = item_valid && item_ready;

   always_comb begin
      override_in      = override_ff;
      cand_fmt_in      = cand_fmt_ff;
      cand_run_in      = cand_run_ff;
      detected_in      = detected_ff;
      active_in        = active_ff;
      warn_raised_in   = warn_raised_ff;
      warn_fmt_in      = warn_fmt_ff;
      formula_known_in = formula_known_ff;
      formula_value_in = formula_value_ff;
      for (int i = 0; i < 3; i++) begin
         seen_valid_in[i] = seen_valid_ff[i];
         seen_num_in[i]   = seen_num_ff[i];
      end
      detect_hit    = 1'b0;
      clear_sess    = 1'b0;
      active_mid    = active_ff;
      eff           = item.code;
      dup           = 1'b0;
      drop_in       = item.early_drop;
      status_in     = 2'd0;
      warn_in       = WARN_NONE;
      flash_in      = 1'b0;
      rframe_in     = 32'd0;
      rtime_in      = 32'd0;
      parse_in      = 1'b0;
      eff_word_full = 16'd0;
      eff_word_in   = 11'd0;

      if (cfg_write) begin
         // Register write: new active format, session and warning cleared
         override_in      = cfg_data;
         active_in        = (cfg_data != FMT_NONE) ? cfg_data : detected_ff;
         formula_known_in = 1'b0;
         formula_value_in = 8'd0;
         warn_raised_in   = 1'b0;
         warn_fmt_in      = FMT_NONE;
         for (int i = 0; i < 3; i++) begin
            seen_valid_in[i] = 1'b0;
         end
      end else if (take && item.early_drop == DROP_NONE) begin
         // Debounce of the incoming format
         if (item.code != cand_fmt_ff) begin
            cand_fmt_in = item.code;
            cand_run_in = 2'd1;
         end else if (cand_run_ff != 2'd3) begin
            cand_run_in = cand_run_ff + 2'd1;
         end
         detect_hit = (32'(cand_run_in) >= DETECT_RUN) && (item.code != detected_ff);
         if (detect_hit) begin
            detected_in = item.code;
            if (override_ff == FMT_NONE && active_ff != item.code) begin
               active_mid = item.code;
               clear_sess = 1'b1;
            end
         end
         if (clear_sess) begin
            formula_known_in = 1'b0;
            formula_value_in = 8'd0;
            for (int i = 0; i < 3; i++) begin
               seen_valid_in[i] = 1'b0;
            end
         end

         // Effective format
         if (override_ff != FMT_NONE) begin
            eff = override_ff;
         end else if (detected_in != FMT_NONE) begin
            eff = detected_in;
         end else if (active_mid != FMT_NONE) begin
            eff = active_mid;
         end
         active_in = (override_ff != FMT_NONE || active_mid == FMT_NONE) ? eff : active_mid;

         // Mismatch warning
         if (override_ff != FMT_NONE && item.code != eff) begin
            if (!warn_raised_ff || warn_fmt_ff != eff) begin
               warn_raised_in = 1'b1;
               warn_fmt_in    = eff;
               warn_in        = WARN_RAISED;
            end
         end else if (warn_raised_ff) begin
            warn_raised_in = 1'b0;
            warn_fmt_in    = FMT_NONE;
            warn_in        = WARN_CLEARED;
         end

         // Formula tracking
         status_in = {1'b0, detect_hit};
         if (eff == FMT_2026 && item.formula_pkt) begin
            if (!formula_known_in || formula_value_in != item.formula_byte) begin
               status_in = status_in + 2'd1;
            end
            formula_known_in = 1'b1;
            formula_value_in = item.formula_byte;
         end

         eff_word_full = {14'd0, eff} + FORMAT_BASE;
         eff_word_in   = eff_word_full[10:0];

         // Duplicate frame rejection
         if (item.slot_valid) begin
            dup = seen_valid_in[item.slot] && (seen_num_ff[item.slot] == item.frame_number);
            if (!dup) begin
               seen_valid_in[item.slot] = 1'b1;
               seen_num_in[item.slot]   = item.frame_number;
            end
         end

         if (dup) begin
            drop_in = DROP_DUP;
         end else begin
            flash_in  = item.flashback;
            rframe_in = item.rewind_frame;
            rtime_in  = item.rewind_time_bits;
            parse_in  = !item.flashback && item.body_hit;
         end
      end
   end

   // Result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (item_ready) begin
         rsp_valid_in = item_valid;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         override_ff      <= FMT_NONE;
         cand_fmt_ff      <= FMT_NONE;
         cand_run_ff      <= 2'd0;
         detected_ff      <= FMT_NONE;
         active_ff        <= FMT_NONE;
         warn_raised_ff   <= 1'b0;
         warn_fmt_ff      <= FMT_NONE;
         formula_known_ff <= 1'b0;
         formula_value_ff <= 8'd0;
         rsp_valid_ff     <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            seen_valid_ff[i] <= 1'b0;
         end
      end else begin
         override_ff      <= override_in;
         cand_fmt_ff      <= cand_fmt_in;
         cand_run_ff      <= cand_run_in;
         detected_ff      <= detected_in;
         active_ff        <= active_in;
         warn_raised_ff   <= warn_raised_in;
         warn_fmt_ff      <= warn_fmt_in;
         formula_known_ff <= formula_known_in;
         formula_value_ff <= formula_value_in;
         rsp_valid_ff     <= rsp_valid_in;
         for (int i = 0; i < 3; i++) begin
            seen_valid_ff[i] <= seen_valid_in[i];
         end
      end
   end

   // Frame numbers and result payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         seen_num_ff[i] <= seen_num_in[i];
      end
      if (take) begin
         drop_ff     <= drop_in;
         eff_word_ff <= eff_word_in;
         status_ff   <= status_in;
         warn_ff     <= warn_in;
         flash_ff    <= flash_in;
         rframe_ff   <= rframe_in;
         rtime_ff    <= rtime_in;
         parse_ff    <= parse_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign drop_cause           = drop_ff;
   assign effective_format     = eff_word_ff;
   assign status_events        = status_ff;
   assign warning_event        = warn_ff;
   assign flashback_seen       = flash_ff;
   assign rewind_frame_out     = rframe_ff;
   assign rewind_time_bits_out = rtime_ff;
   assign parse_body           = parse_ff;

`ifndef NO_ASSERTIONS
   // A raised warning always records the forced format
   a_warn_fmt: assert property (@(posedge clock) disable iff (reset)
      warn_raised_ff == (warn_fmt_ff != FMT_NONE))
      else $error("warning flag and forced format disagree");

   // Warnings exist only under an override
   a_warn_override: assert property (@(posedge clock) disable iff (reset)
      warn_raised_ff |-> override_ff != FMT_NONE)
      else $error("warning raised in auto mode");

   // A debounce candidate always has a run of at least one
   a_cand_run: assert property (@(posedge clock) disable iff (reset)
      cand_fmt_ff != FMT_NONE |-> cand_run_ff != 2'd0)
      else $error("candidate format without a run");

   // No stored formula value without the known flag
   a_formula: assert property (@(posedge clock) disable iff (reset)
      !formula_known_ff |-> formula_value_ff == 8'd0)
      else $error("formula value held while unknown");
`endif

endmodule

`default_nettype wire

[design/telemetry_header_filter_core.sv]
// ----------------------------------------------------------------------------
// telemetry_header_filter_core
// Header filter for telemetry datagrams: drop, format tracking, dispatch.
// ----------------------------------------------------------------------------
// Usage
//   req_*  : one header item per handshake (tvalid/tready), fields in tdata.
//   rsp_*  : one result item for every request item, in order.
//   csr_*  : write of the 2-bit override mode; csr_ready is always high.
//            Write only while no item is in flight.
// Timing
//   An item accepted on req_* shows its result on rsp_tvalid after passing
//   through the classifying front stage, the item queue and the result
//   register of the tracking back end, in that order.
//   Throughput is one item per cycle while rsp_tready stays high.
// Stall
//   When rsp_tready is low the result register holds; the front stage and
//   the queue (two entries by default) keep taking items until they fill,
//   then req_tready drops.
// Reset
//   Synchronous, active high: auto-detect mode, no detected format, empty
//   queue and result register, no warning, no stored frames or formula.
// ----------------------------------------------------------------------------
`default_nettype none

module telemetry_header_filter_core
   import thf_pkg::*;
#(
   parameter int unsigned DETECT_RUN  = DEFAULT_DETECT_RUN,   // 1 .. 3
   parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH   // 2 .. 16
)(
   input  wire logic          clock,
   input  wire logic          reset,
   // Header items
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // datagram_length[10:0], format_word[26:11], packet_kind[34:27],
   // frame_number[66:35], formula_byte[74:67], event_tag[106:75],
   // rewind_frame_in[138:107], rewind_time_bits_in[170:139],
   // want_full_output[171], row_subscription[203:172], zero[207:204]
   input  wire logic [207:0]  req_tdata,
   // Result items
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // drop_cause[1:0], effective_format[12:2], status_events[14:13],
   // warning_event[16:15], flashback_seen[17], rewind_frame_out[49:18],
   // rewind_time_bits_out[81:50], parse_body[82], zero[87:83]
   output logic [87:0]        rsp_tdata,
   // Override mode register
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [1:0]    csr_data
);

   logic         front_valid, front_ready;
   thf_item_type front_item;
   logic         queue_valid, queue_ready;
   thf_item_type queue_item;
   drop_type     drop_cause;
   logic [10:0]  effective_format;
   logic [1:0]   status_events;
   warn_type     warning_event;
   logic         flashback_seen, parse_body;
   logic [31:0]  rewind_frame_out, rewind_time_bits_out;

   assign csr_ready = 1'b1;

   // Classifying front stage
   thf_front u_front (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (req_tvalid),
      .in_ready            (req_tready),
      .datagram_length     (req_tdata[10:0]),
      .format_word         (req_tdata[26:11]),
      .packet_kind         (req_tdata[34:27]),
      .frame_number        (req_tdata[66:35]),
      .formula_byte        (req_tdata[74:67]),
      .event_tag           (req_tdata[106:75]),
      .rewind_frame_in     (req_tdata[138:107]),
      .rewind_time_bits_in (req_tdata[170:139]),
      .want_full_output    (req_tdata[171]),
      .row_subscription    (req_tdata[203:172]),
      .out_valid           (front_valid),
      .out_ready           (front_ready),
      .out_item            (front_item)
   );

   // Item queue
   thf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_item   (queue_item)
   );

   // Tracking back end and result register
   thf_back #(
      .DETECT_RUN (DETECT_RUN)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg_write            (csr_valid),
      .cfg_data             (csr_data),
      .item_valid           (queue_valid),
      .item_ready           (queue_ready),
      .item                 (queue_item),
      .rsp_valid            (rsp_tvalid),
      .rsp_ready            (rsp_tready),
      .drop_cause           (drop_cause),
      .effective_format     (effective_format),
      .status_events        (status_events),
      .warning_event        (warning_event),
      .flashback_seen       (flashback_seen),
      .rewind_frame_out     (rewind_frame_out),
      .rewind_time_bits_out (rewind_time_bits_out),
      .parse_body           (parse_body)
   );

   assign rsp_tdata = {5'd0, parse_body, rewind_time_bits_out, rewind_frame_out,
                       flashback_seen, warning_event, status_events,
                       effective_format, drop_cause};

endmodule

`default_nettype wire
